[src/rpc_pkg.sv]
// Package for the RGB565 pixel correction and scan block.
// Holds the configuration and report types, register indexes and defaults.
// No dependencies.
package rpc_pkg;

  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned RPT_ROW_W    = 10;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_555     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_565      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_555      = 3'd5;

  localparam logic [15:0] KEY_565_RST = 16'h07e0;
  localparam logic [15:0] KEY_555_RST = 16'h03e0;

  typedef struct packed {
    logic        mode_555;
    logic [7:0]  offset_red;
    logic [7:0]  offset_green;
    logic [7:0]  offset_blue;
    logic [15:0] key_565;
    logic [15:0] key_555;
  } cfg_t;

  typedef struct packed {
    logic                 report_valid;
    logic                 has_transparent;
    logic [RPT_ROW_W-1:0] first_opaque_row;
    logic [RPT_ROW_W-1:0] last_opaque_row;
  } rpt_t;

endpackage

[src/rpc_pix_in_if.sv]
// Input channel of the pixel correction block: one RGB565 pixel a word.
// Depends on nothing.
interface rpc_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_in;
  logic        row_end;
  logic        image_end;

  modport source (output valid, pixel_in, row_end, image_end, input ready);
  modport sink (input valid, pixel_in, row_end, image_end, output ready);
endinterface

[src/rpc_pix_out_if.sv]
// Result channel of the pixel correction block: corrected pixel and report.
// Depends on rpc_pkg for the report row width.
interface rpc_pix_out_if;
  logic                          valid;
  logic                          ready;
  logic [15:0]                   pixel_out;
  logic                          report_valid;
  logic                          has_transparent;
  logic [rpc_pkg::RPT_ROW_W-1:0] first_opaque_row;
  logic [rpc_pkg::RPT_ROW_W-1:0] last_opaque_row;

  modport source (output valid, pixel_out, report_valid, has_transparent,
                  first_opaque_row, last_opaque_row, input ready);
  modport sink (input valid, pixel_out, report_valid, has_transparent,
                first_opaque_row, last_opaque_row, output ready);
endinterface

[src/rpc_convert.sv]
// Per-pixel colour path: key substitution, RGB555 conversion, offset and clamp.
// Purely combinational. Depends on rpc_pkg.
module rpc_convert (
  input  logic [15:0]   pixel,
  input  rpc_pkg::cfg_t cfg,
  output logic [15:0]   pixel_res,
  output logic          key_hit
);

  function automatic logic [7:0] add_clamp(input logic [7:0] c, input logic [7:0] off);
    logic [8:0] s;
    s = {1'b0, c} + {1'b0, off};
    return s[8] ? 8'hff : s[7:0];
  endfunction

  logic [4:0]  r5, b5, g5, g5n;
  logic [5:0]  g6;
  logic [15:0] raw555, pix555, pix565;
  logic [7:0]  rc, bc, gc555, gc565;
  logic        is_key_in;

  always_comb begin
    r5  = pixel[15:11];
    g6  = pixel[10:5];
    b5  = pixel[4:0];
    g5  = g6[5:1];
    // Pure green would collide with the usual 555 key, so it is pulled down one step.
    g5n = (r5 == 5'd0 && b5 == 5'd0 && g5 == 5'h1f) ? 5'h1e : g5;
    raw555 = {1'b0, r5, g5n, b5};

    rc    = add_clamp({r5, 3'b000}, cfg.offset_red);
    bc    = add_clamp({b5, 3'b000}, cfg.offset_blue);
    gc555 = add_clamp({g5n, 3'b000}, cfg.offset_green);
    gc565 = add_clamp({g6, 2'b00}, cfg.offset_green);

    pix555 = {1'b0, rc[7:3], gc555[7:3], bc[7:3]};
    pix565 = {rc[7:3], gc565[7:2], bc[7:3]};

    is_key_in = (pixel == cfg.key_565);

    if (cfg.mode_555) begin
      if (is_key_in) begin
        pixel_res = cfg.key_555;
      end else if (raw555 == cfg.key_555) begin
        pixel_res = raw555;
      end else begin
        pixel_res = pix555;
      end
    end else begin
      pixel_res = is_key_in ? pixel : pix565;
    end

    // A corrected pixel that lands on the key also counts as transparent.
    key_hit = (pixel_res == cfg.key_565);
  end

endmodule

[src/rpc_scan.sv]
// Row tracking and end-of-image report of key and opaque pixels.
// Depends on rpc_pkg for the report type.
module rpc_scan #(
  parameter int unsigned MAX_ROWS = rpc_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          mode_555,
  input  logic          key_hit,
  input  logic          row_end,
  input  logic          image_end,
  output rpc_pkg::rpt_t rpt
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

  logic [RW-1:0] row_r, row_nxt;
  logic          key_seen_r, key_seen_nxt;
  logic          opaque_r, opaque_nxt;
  logic [RW-1:0] first_r, first_nxt;
  logic [RW-1:0] last_r, last_nxt;

  logic          opq_now, key_now;
  logic          key_upd, opq_upd;
  logic [RW-1:0] first_upd, last_upd;

  function automatic logic [rpc_pkg::RPT_ROW_W-1:0] rpt_row(input logic [RW-1:0] row);
    logic [RW+rpc_pkg::RPT_ROW_W-1:0] ext;
    ext = {{rpc_pkg::RPT_ROW_W{1'b0}}, row};
    return ext[rpc_pkg::RPT_ROW_W-1:0];
  endfunction

  always_comb begin
    // No key or opaque pixel is tracked while the block converts to RGB555.
    opq_now   = !mode_555 && !key_hit;
    key_now   = !mode_555 && key_hit;
    key_upd   = key_seen_r | key_now;
    opq_upd   = opaque_r | opq_now;
    first_upd = (opq_now && !opaque_r) ? row_r : first_r;
    last_upd  = opq_now ? row_r : last_r;

    rpt = '0;
    if (image_end) begin
      rpt.report_valid = 1'b1;
      if (mode_555) begin
        rpt.has_transparent = 1'b1;
        rpt.last_opaque_row = rpt_row(row_r);
      end else begin
        rpt.has_transparent  = key_upd;
        rpt.first_opaque_row = opq_upd ? rpt_row(first_upd) : '0;
        rpt.last_opaque_row  = opq_upd ? rpt_row(last_upd) : rpt_row(row_r);
      end
    end

    row_nxt      = row_r;
    key_seen_nxt = key_seen_r;
    opaque_nxt   = opaque_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    if (accept) begin
      if (image_end) begin
        row_nxt      = '0;
        key_seen_nxt = 1'b0;
        opaque_nxt   = 1'b0;
        first_nxt    = '0;
        last_nxt     = '0;
      end else begin
        key_seen_nxt = key_upd;
        opaque_nxt   = opq_upd;
        first_nxt    = first_upd;
        last_nxt     = last_upd;
        if (row_end && row_r < ROW_LAST) begin
          row_nxt = row_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      key_seen_r <= 1'b0;
      opaque_r   <= 1'b0;
      first_r    <= '0;
      last_r     <= '0;
    end else begin
      row_r      <= row_nxt;
      key_seen_r <= key_seen_nxt;
      opaque_r   <= opaque_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
    end
  end

  a_rows_clear_without_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    !opaque_r |-> (first_r == '0 && last_r == '0))
    else $error("row marks set before any opaque pixel");

  a_first_not_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    opaque_r |-> first_r <= last_r)
    else $error("first opaque row lies after last opaque row");

  a_image_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && image_end |=> (row_r == '0 && !key_seen_r && !opaque_r))
    else $error("scan state not cleared after end of image");

endmodule

[src/rgb565_pixel_correct_and_scan.sv]
// Top level of the RGB565 pixel correction and scan block.
// Depends on rpc_pkg, rpc_pix_in_if, rpc_pix_out_if, rpc_convert and rpc_scan.
//
// Usage:
//   Pixels arrive on in_pix, one word per RGB565 pixel in row-major order,
//   with row_end on the last pixel of each row and image_end on the last
//   pixel of the image. Every input word yields exactly one result word on
//   out_pix: the corrected pixel, plus the opacity report on the word that
//   carries image_end.
//   The colour path and the scan update sit between the input port and a
//   single result register. Throughput is one pixel per clock; the result
//   register frees up in the same cycle in which its word is taken, so
//   in_pix.ready stays high while out_pix.ready is high.
//   When the receiver stalls, the pending word holds in the result register
//   and in_pix.ready drops until it is taken.
//   The configuration registers are written through cfg_we, cfg_idx and
//   cfg_data; the user writes them only while no word is in flight, which
//   the block does not enforce. Synchronous reset empties the result
//   register and returns the scan state and the configuration to their
//   defaults (keys 0x07E0 and 0x03E0, all else zero).
module rgb565_pixel_correct_and_scan #(
  parameter int unsigned MAX_ROWS = rpc_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rpc_pix_in_if.sink                       in_pix,
  rpc_pix_out_if.source                    out_pix,
  input  logic                             cfg_we,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rpc_pkg::cfg_t cfg_r, cfg_nxt;
  rpc_pkg::rpt_t rpt, rpt_r;
  logic [15:0]   pixel_res, pixel_r;
  logic          key_hit;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        rpc_pkg::CFG_MODE_555:     cfg_nxt.mode_555     = cfg_data[0];
        rpc_pkg::CFG_OFFSET_RED:   cfg_nxt.offset_red   = cfg_data[7:0];
        rpc_pkg::CFG_OFFSET_GREEN: cfg_nxt.offset_green = cfg_data[7:0];
        rpc_pkg::CFG_OFFSET_BLUE:  cfg_nxt.offset_blue  = cfg_data[7:0];
        rpc_pkg::CFG_KEY_565:      cfg_nxt.key_565      = cfg_data;
        rpc_pkg::CFG_KEY_555:      cfg_nxt.key_555      = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_555     <= 1'b0;
      cfg_r.offset_red   <= '0;
      cfg_r.offset_green <= '0;
      cfg_r.offset_blue  <= '0;
      cfg_r.key_565      <= rpc_pkg::KEY_565_RST;
      cfg_r.key_555      <= rpc_pkg::KEY_555_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_pix.ready = !out_valid_r || out_pix.ready;
  assign accept       = in_pix.valid && in_pix.ready;

  rpc_convert u_convert (
    .pixel     (in_pix.pixel_in),
    .cfg       (cfg_r),
    .pixel_res (pixel_res),
    .key_hit   (key_hit)
  );

  rpc_scan #(
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode_555  (cfg_r.mode_555),
    .key_hit   (key_hit),
    .row_end   (in_pix.row_end),
    .image_end (in_pix.image_end),
    .rpt       (rpt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_pix.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_r <= pixel_res;
      rpt_r   <= rpt;
    end
  end

  assign out_pix.valid            = out_valid_r;
  assign out_pix.pixel_out        = pixel_r;
  assign out_pix.report_valid     = rpt_r.report_valid;
  assign out_pix.has_transparent  = rpt_r.has_transparent;
  assign out_pix.first_opaque_row = rpt_r.first_opaque_row;
  assign out_pix.last_opaque_row  = rpt_r.last_opaque_row;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted pixel produced no result word");

  a_report_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !rpt_r.report_valid |->
      (!rpt_r.has_transparent && rpt_r.first_opaque_row == '0 &&
       rpt_r.last_opaque_row == '0))
    else $error("report fields set on a word without the report");

  a_key_swap_555: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cfg_r.mode_555 && in_pix.pixel_in == cfg_r.key_565 |=>
      pixel_r == $past(cfg_r.key_555))
    else $error("key pixel not replaced by the 555 key");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for rgb565_pixel_correct_and_scan.
// Depends on rpc_pkg, rpc_pix_in_if, rpc_pix_out_if and the block itself.
// Drives a short directed raster, then random images, and checks every word.
module tb_top;

  localparam int unsigned ROW_LIMIT = rpc_pkg::MAX_ROWS_DEF - 1;

  typedef struct packed {
    logic [15:0]   pixel;
    rpc_pkg::rpt_t rpt;
  } pix_word_t;

  // Predicts the corrected pixel and the opacity report for each word sent.
  class pixel_scoreboard;
    rpc_pkg::cfg_t regs;
    int unsigned   row_index;
    logic          key_seen;
    logic          opaque_found;
    int unsigned   first_row;
    int unsigned   last_row;
    pix_word_t     expected_q[$];
    int            fail_count;

    function new();
      regs = '0;
      regs.key_565 = rpc_pkg::KEY_565_RST;
      regs.key_555 = rpc_pkg::KEY_555_RST;
      clear_scan();
      fail_count = 0;
    endfunction

    function void clear_scan();
      row_index = 0;
      key_seen = 1'b0;
      opaque_found = 1'b0;
      first_row = 0;
      last_row = 0;
    endfunction

    function void load_regs(rpc_pkg::cfg_t c);
      regs = c;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] add_sat(logic [7:0] chan, logic [7:0] offset);
      logic [8:0] sum;
      sum = {1'b0, chan} + {1'b0, offset};
      return sum[8] ? 8'hff : sum[7:0];
    endfunction

    function void note_word(logic [15:0] px, logic row_end, logic image_end);
      logic [4:0] r5, g5, b5;
      logic [7:0] r8, g8, b8;
      logic [15:0] res;
      pix_word_t want;
      r5 = px[15:11];
      b5 = px[4:0];
      res = px;
      if (regs.mode_555) begin
        if (px == regs.key_565) begin
          res = regs.key_555;
        end else begin
          g5 = px[10:6];
          // Pure green is nudged down one step so that it cannot pass for the key.
          if (r5 == 5'd0 && b5 == 5'd0 && g5 == 5'h1f) g5 = 5'h1e;
          res = {1'b0, r5, g5, b5};
          if (res != regs.key_555) begin
            r8 = add_sat({r5, 3'b000}, regs.offset_red);
            g8 = add_sat({g5, 3'b000}, regs.offset_green);
            b8 = add_sat({b5, 3'b000}, regs.offset_blue);
            res = {1'b0, r8[7:3], g8[7:3], b8[7:3]};
          end
        end
      end else begin
        if (px != regs.key_565) begin
          r8 = add_sat({r5, 3'b000}, regs.offset_red);
          g8 = add_sat({px[10:5], 2'b00}, regs.offset_green);
          b8 = add_sat({b5, 3'b000}, regs.offset_blue);
          res = {r8[7:3], g8[7:2], b8[7:3]};
        end
        // A corrected pixel that lands on the key counts as transparent.
        if (res == regs.key_565) begin
          key_seen = 1'b1;
        end else begin
          if (!opaque_found) first_row = row_index;
          opaque_found = 1'b1;
          last_row = row_index;
        end
      end
      want.pixel = res;
      want.rpt = '0;
      if (image_end) begin
        want.rpt.report_valid = 1'b1;
        if (regs.mode_555) begin
          want.rpt.has_transparent = 1'b1;
          want.rpt.last_opaque_row = row_index[rpc_pkg::RPT_ROW_W-1:0];
        end else begin
          want.rpt.has_transparent = key_seen;
          want.rpt.first_opaque_row = opaque_found ?
                                      first_row[rpc_pkg::RPT_ROW_W-1:0] : '0;
          want.rpt.last_opaque_row = opaque_found ?
                                     last_row[rpc_pkg::RPT_ROW_W-1:0] :
                                     row_index[rpc_pkg::RPT_ROW_W-1:0];
        end
        clear_scan();
      end else if (row_end && row_index < ROW_LIMIT) begin
        row_index++;
      end
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task check_word(pix_word_t got);
      pix_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("word %h arrived with nothing expected", got.pixel));
      end else begin
        want = expected_q.pop_front();
        compare_field("pixel_out", got.pixel, want.pixel);
        compare_field("report_valid", 16'(got.rpt.report_valid),
                      16'(want.rpt.report_valid));
        compare_field("has_transparent", 16'(got.rpt.has_transparent),
                      16'(want.rpt.has_transparent));
        compare_field("first_opaque_row", 16'(got.rpt.first_opaque_row),
                      16'(want.rpt.first_opaque_row));
        compare_field("last_opaque_row", 16'(got.rpt.last_opaque_row),
                      16'(want.rpt.last_opaque_row));
      end
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data;

  rpc_pix_in_if  in_if ();
  rpc_pix_out_if out_if ();

  rgb565_pixel_correct_and_scan dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_if),
    .out_pix  (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  pixel_scoreboard sb;
  bit quiet;

  // Raster generator state: current image size and position.
  int unsigned img_w, img_h, col, row;
  bit noisy, force_tall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_key(logic [15:0] dflt);
    case ($urandom_range(0, 5))
      0, 1: return dflt;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rpc_pkg::cfg_t random_regs();
    rpc_pkg::cfg_t c;
    c.mode_555 = 1'($urandom_range(0, 1));
    c.offset_red = pick_offset();
    c.offset_green = pick_offset();
    c.offset_blue = pick_offset();
    c.key_565 = pick_key(rpc_pkg::KEY_565_RST);
    c.key_555 = pick_key(rpc_pkg::KEY_555_RST);
    return c;
  endfunction

  // Pixels are biased towards keys, near misses and the pure green corner.
  function automatic logic [15:0] pick_pixel();
    logic [15:0] k555;
    k555 = sb.regs.key_555;
    case ($urandom_range(0, 9))
      0: return sb.regs.key_565;
      1: return sb.regs.key_565 ^ (16'h0001 << $urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? 16'h07c0 : 16'h07e0;
      3: return 16'h0000;
      4: return 16'hffff;
      5: return {k555[14:10], k555[9:5], 1'($urandom_range(0, 1)), k555[4:0]};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void next_item(output logic [15:0] px, output logic re,
                                    output logic ie);
    if (col == 0 && row == 0) begin
      if (force_tall) begin
        img_w = 1;
        img_h = rpc_pkg::MAX_ROWS_DEF + 6;
        noisy = 1'b0;
        force_tall = 1'b0;
      end else begin
        img_w = $urandom_range(1, 8);
        img_h = $urandom_range(1, 6);
        noisy = ($urandom_range(0, 7) == 0);
      end
    end
    px = pick_pixel();
    if (noisy) begin
      re = 1'($urandom_range(0, 1));
      ie = ($urandom_range(0, 15) == 0);
    end else begin
      re = (col == img_w - 1);
      ie = re && (row == img_h - 1);
    end
    if (ie) begin
      col = 0;
      row = 0;
    end else if (re) begin
      col = 0;
      row++;
    end else begin
      col++;
    end
  endfunction

  // Returns in the low phase just before the edge that accepts the word.
  task automatic send_word(logic [15:0] px, logic re, logic ie);
    int hold;
    hold = draw_gap();
    if (hold > 0) begin
      @(posedge clk);
      in_if.valid <= 1'b0;
      repeat (hold - 1) @(posedge clk);
    end
    @(posedge clk);
    in_if.valid <= 1'b1;
    in_if.pixel_in <= px;
    in_if.row_end <= re;
    in_if.image_end <= ie;
    do @(negedge clk); while (in_if.ready !== 1'b1);
    sb.note_word(px, re, ie);
  endtask

  task automatic idle_input();
    @(posedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(rpc_pkg::cfg_t c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= rpc_pkg::CFG_MODE_555;
    cfg_data <= {15'd0, c.mode_555};
    @(posedge clk);
    cfg_idx <= rpc_pkg::CFG_OFFSET_RED;
    cfg_data <= {8'd0, c.offset_red};
    @(posedge clk);
    cfg_idx <= rpc_pkg::CFG_OFFSET_GREEN;
    cfg_data <= {8'd0, c.offset_green};
    @(posedge clk);
    cfg_idx <= rpc_pkg::CFG_OFFSET_BLUE;
    cfg_data <= {8'd0, c.offset_blue};
    @(posedge clk);
    cfg_idx <= rpc_pkg::CFG_KEY_565;
    cfg_data <= c.key_565;
    @(posedge clk);
    cfg_idx <= rpc_pkg::CFG_KEY_555;
    cfg_data <= c.key_555;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_regs(c);
  endtask

  task automatic settle_and_write(rpc_pkg::cfg_t c);
    idle_input();
    drain();
    write_regs(c);
  endtask

  initial begin : result_sink
    int hold;
    pix_word_t got;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_gap();
      repeat (hold) begin
        @(posedge clk);
        out_if.ready <= 1'b0;
      end
      @(posedge clk);
      out_if.ready <= 1'b1;
      do @(negedge clk); while (out_if.valid !== 1'b1);
      got.pixel = out_if.pixel_out;
      got.rpt.report_valid = out_if.report_valid;
      got.rpt.has_transparent = out_if.has_transparent;
      got.rpt.first_opaque_row = out_if.first_opaque_row;
      got.rpt.last_opaque_row = out_if.last_opaque_row;
      sb.check_word(got);
    end
  end

  initial begin : stimulus
    rpc_pkg::cfg_t c;
    logic [15:0] px;
    logic re, ie;
    int n_items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = rpc_pkg::CFG_MODE_555;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.pixel_in = '0;
    in_if.row_end = 1'b0;
    in_if.image_end = 1'b0;
    quiet = 1'b0;
    img_w = 1;
    img_h = 1;
    col = 0;
    row = 0;
    noisy = 1'b0;
    force_tall = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Default registers: key pixels, extremes, a row end and an all-key image.
    send_word(16'h07e0, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hffff, 1'b1, 1'b0);
    send_word(16'h07e0, 1'b0, 1'b1);
    send_word(16'h07e0, 1'b1, 1'b0);
    send_word(16'h07e0, 1'b0, 1'b1);

    // Full offsets drive every non-key pixel onto a key of all ones.
    c = '0;
    c.offset_red = 8'hff;
    c.offset_green = 8'hff;
    c.offset_blue = 8'hff;
    c.key_565 = 16'hffff;
    c.key_555 = rpc_pkg::KEY_555_RST;
    settle_and_write(c);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h1234, 1'b0, 1'b1);
    send_word(16'h8410, 1'b1, 1'b0);

    // Switch to 555 in the middle of an image: pure green, key hits, report.
    c = '0;
    c.mode_555 = 1'b1;
    c.key_565 = 16'h1234;
    c.key_555 = 16'h7fff;
    settle_and_write(c);
    send_word(16'h07c0, 1'b0, 1'b0);
    send_word(16'h07e0, 1'b0, 1'b0);
    send_word(16'h1234, 1'b0, 1'b0);
    send_word(16'hffff, 1'b0, 1'b0);
    send_word(16'h0001, 1'b0, 1'b1);

    c = '0;
    c.mode_555 = 1'b1;
    c.offset_red = 8'hff;
    c.offset_blue = 8'h80;
    c.key_565 = rpc_pkg::KEY_565_RST;
    c.key_555 = rpc_pkg::KEY_555_RST;
    settle_and_write(c);
    send_word(16'h07e0, 1'b1, 1'b0);
    send_word(16'h8410, 1'b0, 1'b0);
    send_word(16'hf800, 1'b0, 1'b1);

    // Image end together with row end, and a key of zero.
    c = '0;
    c.offset_red = 8'h01;
    c.offset_green = 8'h02;
    c.offset_blue = 8'h03;
    c.key_565 = 16'h0000;
    c.key_555 = 16'hffff;
    settle_and_write(c);
    send_word(16'h5555, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b1);
    send_word(16'haaaa, 1'b0, 1'b1);

    // Random images; a phase may start in the middle of an image.
    for (int ph = 0; ph < 12; ph++) begin
      c = random_regs();
      if (ph == 1) begin
        c.offset_red = 8'hff;
        c.offset_green = 8'hff;
        c.offset_blue = 8'hff;
      end else if (ph == 2) begin
        c.offset_red = 8'h00;
        c.offset_green = 8'h00;
        c.offset_blue = 8'h00;
      end
      settle_and_write(c);
      quiet = ($urandom_range(0, 3) == 0);
      // One phase carries an image taller than the row counter can number.
      if (ph == 5) force_tall = 1'b1;
      n_items = (ph == 5) ? 1100 : 36;
      for (int i = 0; i < n_items; i++) begin
        next_item(px, re, ie);
        send_word(px, re, ie);
        if (ph == 3 && i == 20) begin
          idle_input();
          drain();
        end
      end
    end

    idle_input();
    drain();
    repeat (5) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[rgb565_pixel_correct_and_scan.f]
src/rpc_pkg.sv
src/rpc_pix_in_if.sv
src/rpc_pix_out_if.sv
src/rpc_convert.sv
src/rpc_scan.sv
src/rgb565_pixel_correct_and_scan.sv
dv/tb_top.sv
